// File: rtl/omtl_pkg.sv
// ----------------------------------------------------------------------------
// omtl_pkg: shared types and constants for the tag list unit
// Command and status codes, datapath operations and controller handshake.
// ----------------------------------------------------------------------------
package omtl_pkg;

	localparam int POOL_NODES_DEF = 256;
	localparam int TAG_BITS_DEF   = 32;
	localparam int NODE_W         = 8;
	localparam int CMD_W          = 2;
	localparam int STAT_W         = 2;
	localparam int ORD_W          = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_AFTER  = 2'd0,
		CMD_INS_BEFORE = 2'd1,
		CMD_COMPARE    = 2'd2,
		CMD_DELETE     = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_INVALID = 2'd2
	} stat_t;

	localparam logic signed [ORD_W-1:0] ORD_SAME    = 2'sd0;
	localparam logic signed [ORD_W-1:0] ORD_A_FIRST = 2'sd1;
	localparam logic signed [ORD_W-1:0] ORD_B_FIRST = -2'sd1;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT,
		OP_LOAD,
		OP_SCAN,
		OP_SET_X_A,
		OP_SET_X_PREV,
		OP_BASE,
		OP_WALK,
		OP_DIV_GO,
		OP_RL_INIT,
		OP_RL_WR,
		OP_RL_NX,
		OP_LINK1,
		OP_LINK2,
		OP_CAP0,
		OP_CAPA,
		OP_CMP,
		OP_DEL,
		OP_SET_ERR,
		OP_SET_FULL,
		OP_PUSH
	} op_t;

	typedef enum logic [2:0] {
		RS_A,
		RS_B,
		RS_ZERO,
		RS_X,
		RS_XJ,
		RS_XK
	} rsel_t;

	typedef struct packed {
		op_t   op;
		rsel_t rsel;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic a_valid;
		logic b_valid;
		logic a_zero;
		logic found;
		logic scan_end;
		logic empty;
		logic walk_stop;
		logic div_busy;
		logic k_done;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/omtl_req_if.sv
// ----------------------------------------------------------------------------
// omtl_req_if: command channel
// Carries one command word per handshake.
// ----------------------------------------------------------------------------
interface omtl_req_if;
	import omtl_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;

	modport source (output valid, command, node_a, node_b, input ready);
	modport sink (input valid, command, node_a, node_b, output ready);
endinterface

// File: rtl/omtl_rsp_if.sv
// ----------------------------------------------------------------------------
// omtl_rsp_if: result channel
// Carries one result word per handshake.
// ----------------------------------------------------------------------------
interface omtl_rsp_if;
	import omtl_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic [NODE_W-1:0]       new_node;
	logic signed [ORD_W-1:0] order_result;

	modport source (output valid, status, new_node, order_result, input ready);
	modport sink (input valid, status, new_node, order_result, output ready);
endinterface

// File: rtl/omtl_div.sv
// ----------------------------------------------------------------------------
// omtl_div: restoring divider
// Produces one quotient bit per cycle; busy from start until all N quotient bits are done.
// ----------------------------------------------------------------------------
module omtl_div #(
	parameter int N = 33,
	parameter int D = 9
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         busy,
	output logic [N-1:0] quotient,
	output logic [D-1:0] remainder
);
	localparam int CW = $clog2(N + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [N-1:0]  quo_q;
	logic [D-1:0]  rem_q;
	logic [D:0]    shifted;
	logic [D:0]    diff;
	logic          take;

	assign shifted = {rem_q, quo_q[N-1]};
	assign take    = shifted >= {1'b0, divisor};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(N);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[N-2:0], take};
			rem_q <= take ? diff[D-1:0] : shifted[D-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// File: rtl/omtl_dp.sv
// ----------------------------------------------------------------------------
// omtl_dp: tag list datapath
// Node memories, slot occupancy, free slot scan, walk and relabel arithmetic,
// and the result register.
// ----------------------------------------------------------------------------
module omtl_dp #(
	parameter int POOL_NODES = omtl_pkg::POOL_NODES_DEF,
	parameter int TAG_BITS   = omtl_pkg::TAG_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  omtl_pkg::dp_cmd_t                 cmd,
	output omtl_pkg::dp_stat_t                st,
	input  logic [omtl_pkg::CMD_W-1:0]        req_command,
	input  logic [omtl_pkg::NODE_W-1:0]       req_node_a,
	input  logic [omtl_pkg::NODE_W-1:0]       req_node_b,
	input  logic                              rsp_ready,
	output logic                              rsp_valid,
	output logic [omtl_pkg::STAT_W-1:0]       rsp_status,
	output logic [omtl_pkg::NODE_W-1:0]       rsp_new_node,
	output logic signed [omtl_pkg::ORD_W-1:0] rsp_order_result
);
	import omtl_pkg::*;

	localparam int IW  = $clog2(POOL_NODES);
	localparam int JW  = $clog2(POOL_NODES + 2);
	localparam int WW  = TAG_BITS + 1;
	localparam int SQW = 2 * JW;
	localparam int CW  = (WW > SQW) ? WW : SQW;
	localparam int CH  = 8;
	localparam int NCH = (POOL_NODES + CH - 1) / CH;
	localparam int SCW = $clog2(NCH + 1);
	localparam logic [JW-1:0]       J_LIM  = JW'(POOL_NODES);
	localparam logic [WW-1:0]       W_FULL = {1'b1, {TAG_BITS{1'b0}}};
	localparam logic [TAG_BITS-1:0] T_MID  = {1'b0, {(TAG_BITS-1){1'b1}}};

	logic [TAG_BITS-1:0] tag_mem  [POOL_NODES];
	logic [IW-1:0]       next_mem [POOL_NODES];
	logic [IW-1:0]       prev_mem [POOL_NODES];
	logic [TAG_BITS-1:0] tag_rd;
	logic [IW-1:0]       next_rd;
	logic [IW-1:0]       prev_rd;
	logic [IW-1:0]       raddr;

	logic                tag_we, next_we, prev_we;
	logic [IW-1:0]       tag_wa, next_wa, prev_wa;
	logic [TAG_BITS-1:0] tag_wd;
	logic [IW-1:0]       next_wd, prev_wd;

	logic [POOL_NODES-1:0] used_q;
	cmd_t                  cmd_q;
	logic [NODE_W-1:0]     a_q, b_q;
	logic [SCW-1:0]        scan_q;
	logic                  found_q;
	logic [IW-1:0]         h_q, x_q, nx_q, xj_q, xk_q;
	logic [TAG_BITS-1:0]   base_q, q_q, t0_q, ta_q;
	logic [JW-1:0]         j_q, k_q, r_q;
	logic [SQW-1:0]        jsq_q;
	logic [WW-1:0]         w_q;

	stat_t                   res_stat_q;
	logic [NODE_W-1:0]       res_new_q;
	logic signed [ORD_W-1:0] res_ord_q;
	logic                    ovalid_q;
	stat_t                   ostat_q;
	logic [NODE_W-1:0]       onew_q;
	logic signed [ORD_W-1:0] oord_q;

	logic                scan_hit;
	logic [IW-1:0]       scan_slot;
	int                  s;
	logic [TAG_BITS-1:0] w_raw;
	logic                w_bad;
	logic [WW-1:0]       w_val;
	logic                walk_stop;
	logic                div_busy;
	logic [WW-1:0]       div_quo;
	logic [JW-1:0]       div_rem;
	logic [TAG_BITS-1:0] quo_t;
	logic [JW:0]         rsum;
	logic                rwrap;
	logic [TAG_BITS-1:0] rel, new_tag;
	logic [TAG_BITS-1:0] cmp_a, cmp_b;
	logic                a_valid, b_valid;

	always_comb begin
		case (cmd.rsel)
			RS_A:    raddr = IW'(a_q);
			RS_B:    raddr = IW'(b_q);
			RS_ZERO: raddr = '0;
			RS_X:    raddr = x_q;
			RS_XJ:   raddr = xj_q;
			RS_XK:   raddr = xk_q;
			default: raddr = '0;
		endcase
	end

	always_comb begin
		scan_hit  = 1'b0;
		scan_slot = '0;
		for (int i = CH - 1; i >= 0; i--) begin
			s = int'(scan_q) * CH + i;
			if (s < POOL_NODES && !used_q[IW'(s)]) begin
				scan_hit  = 1'b1;
				scan_slot = IW'(s);
			end
		end
	end

	assign a_valid = (int'(a_q) < POOL_NODES) && used_q[IW'(a_q)];
	assign b_valid = (int'(b_q) < POOL_NODES) && used_q[IW'(b_q)];

	assign w_raw     = tag_rd - base_q;
	assign w_bad     = (w_raw == '0) || (xj_q == x_q) || (j_q > J_LIM);
	assign w_val     = w_bad ? W_FULL : {1'b0, w_raw};
	assign walk_stop = w_bad || (CW'(w_val) > CW'(jsq_q));

	assign quo_t   = div_quo[TAG_BITS-1:0];
	assign rsum    = {1'b0, r_q} + {1'b0, div_rem};
	assign rwrap   = rsum >= {1'b0, j_q};
	assign rel     = (j_q > JW'(1)) ? quo_t : w_q[TAG_BITS-1:0];
	assign new_tag = (nx_q == x_q) ? T_MID : base_q + (rel >> 1);
	assign cmp_a   = ta_q - t0_q;
	assign cmp_b   = tag_rd - t0_q;

	omtl_div #(.N(WW), .D(JW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.op == OP_DIV_GO),
		.dividend  (w_q),
		.divisor   (j_q),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		tag_we  = 1'b0;
		tag_wa  = '0;
		tag_wd  = '0;
		next_we = 1'b0;
		next_wa = '0;
		next_wd = '0;
		prev_we = 1'b0;
		prev_wa = '0;
		prev_wd = '0;
		case (cmd.op)
			OP_INIT: begin
				tag_we  = 1'b1;
				next_we = 1'b1;
				prev_we = 1'b1;
			end
			OP_RL_WR: begin
				tag_we = 1'b1;
				tag_wa = xk_q;
				tag_wd = base_q + q_q;
			end
			OP_LINK1: begin
				tag_we  = 1'b1;
				tag_wa  = h_q;
				tag_wd  = new_tag;
				next_we = 1'b1;
				next_wa = h_q;
				next_wd = nx_q;
				prev_we = 1'b1;
				prev_wa = h_q;
				prev_wd = x_q;
			end
			OP_LINK2: begin
				next_we = 1'b1;
				next_wa = x_q;
				next_wd = h_q;
				prev_we = 1'b1;
				prev_wa = nx_q;
				prev_wd = h_q;
			end
			OP_DEL: begin
				next_we = 1'b1;
				next_wa = prev_rd;
				next_wd = next_rd;
				prev_we = 1'b1;
				prev_wa = next_rd;
				prev_wd = prev_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		tag_rd <= tag_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd <= next_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		prev_rd <= prev_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= POOL_NODES'(1);
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LINK2) begin
				used_q[h_q] <= 1'b1;
			end else if (cmd.op == OP_DEL) begin
				used_q[IW'(a_q)] <= 1'b0;
			end
			if (cmd.op == OP_PUSH) begin
				ovalid_q <= 1'b1;
			end else if (rsp_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cmd_q   <= cmd_t'(req_command);
				a_q     <= req_node_a;
				b_q     <= req_node_b;
				scan_q  <= '0;
				found_q <= 1'b0;
			end
			OP_SCAN: begin
				scan_q <= scan_q + 1'b1;
				if (scan_hit) begin
					found_q <= 1'b1;
					h_q     <= scan_slot;
				end
			end
			OP_SET_X_A:    x_q <= IW'(a_q);
			OP_SET_X_PREV: x_q <= prev_rd;
			OP_BASE: begin
				base_q <= tag_rd;
				nx_q   <= next_rd;
				xj_q   <= next_rd;
				j_q    <= JW'(1);
				jsq_q  <= SQW'(1);
			end
			OP_WALK: begin
				w_q <= w_val;
				if (!walk_stop) begin
					j_q   <= j_q + 1'b1;
					jsq_q <= jsq_q + SQW'({j_q, 1'b1});
					xj_q  <= next_rd;
				end
			end
			OP_RL_INIT: begin
				k_q  <= JW'(1);
				q_q  <= quo_t;
				r_q  <= div_rem;
				xk_q <= nx_q;
			end
			OP_RL_WR: begin
				k_q <= k_q + 1'b1;
				if (rwrap) begin
					r_q <= JW'(rsum - {1'b0, j_q});
					q_q <= q_q + quo_t + 1'b1;
				end else begin
					r_q <= rsum[JW-1:0];
					q_q <= q_q + quo_t;
				end
			end
			OP_RL_NX: xk_q <= next_rd;
			OP_LINK2: begin
				res_stat_q <= STAT_OK;
				res_new_q  <= NODE_W'(h_q);
				res_ord_q  <= ORD_SAME;
			end
			OP_CAP0: t0_q <= tag_rd;
			OP_CAPA: ta_q <= tag_rd;
			OP_CMP: begin
				res_stat_q <= STAT_OK;
				res_new_q  <= '0;
				if (cmp_a > cmp_b) begin
					res_ord_q <= ORD_B_FIRST;
				end else if (cmp_a < cmp_b) begin
					res_ord_q <= ORD_A_FIRST;
				end else begin
					res_ord_q <= ORD_SAME;
				end
			end
			OP_DEL: begin
				res_stat_q <= STAT_OK;
				res_new_q  <= '0;
				res_ord_q  <= ORD_SAME;
			end
			OP_SET_ERR: begin
				res_stat_q <= STAT_INVALID;
				res_new_q  <= '0;
				res_ord_q  <= ORD_SAME;
			end
			OP_SET_FULL: begin
				res_stat_q <= STAT_FULL;
				res_new_q  <= '0;
				res_ord_q  <= ORD_SAME;
			end
			OP_PUSH: begin
				ostat_q <= res_stat_q;
				onew_q  <= res_new_q;
				oord_q  <= res_ord_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st.cmd       = cmd_q;
		st.a_valid   = a_valid;
		st.b_valid   = b_valid;
		st.a_zero    = (a_q == '0);
		st.found     = found_q;
		st.scan_end  = (scan_q == SCW'(NCH));
		st.empty     = (nx_q == x_q);
		st.walk_stop = walk_stop;
		st.div_busy  = div_busy;
		st.k_done    = (k_q == j_q);
		st.out_free  = !ovalid_q || rsp_ready;
	end

	assign rsp_valid        = ovalid_q;
	assign rsp_status       = ostat_q;
	assign rsp_new_node     = onew_q;
	assign rsp_order_result = oord_q;
endmodule

// File: rtl/omtl_ctrl.sv
// ----------------------------------------------------------------------------
// omtl_ctrl: tag list controller
// Sequences the datapath through decode, free slot scan, walk, divide,
// relabel, relink, compare and delete.
// ----------------------------------------------------------------------------
module omtl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  omtl_pkg::dp_stat_t st,
	output omtl_pkg::dp_cmd_t  cmd
);
	import omtl_pkg::*;

	typedef enum logic [20:0] {
		S_INIT = 21'h000001,
		S_IDLE = 21'h000002,
		S_DEC  = 21'h000004,
		S_SCAN = 21'h000008,
		S_SETX = 21'h000010,
		S_RX   = 21'h000020,
		S_BASE = 21'h000040,
		S_WRD  = 21'h000080,
		S_WEV  = 21'h000100,
		S_DGO  = 21'h000200,
		S_DWT  = 21'h000400,
		S_RLI  = 21'h000800,
		S_RLW  = 21'h001000,
		S_RLN  = 21'h002000,
		S_LK1  = 21'h004000,
		S_LK2  = 21'h008000,
		S_C1   = 21'h010000,
		S_C2   = 21'h020000,
		S_C3   = 21'h040000,
		S_DEL  = 21'h080000,
		S_PUSH = 21'h100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		cmd.rsel  = RS_A;
		req_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.op  = OP_INIT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (st.cmd)
					CMD_INS_AFTER, CMD_INS_BEFORE: begin
						if (!st.a_valid) begin
							cmd.op  = OP_SET_ERR;
							state_d = S_PUSH;
						end else begin
							state_d = S_SCAN;
						end
					end
					CMD_COMPARE: begin
						if (!st.a_valid || !st.b_valid) begin
							cmd.op  = OP_SET_ERR;
							state_d = S_PUSH;
						end else begin
							cmd.rsel = RS_ZERO;
							state_d  = S_C1;
						end
					end
					default: begin
						if (st.a_zero || !st.a_valid) begin
							cmd.op  = OP_SET_ERR;
							state_d = S_PUSH;
						end else begin
							cmd.rsel = RS_A;
							state_d  = S_DEL;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (st.found) begin
					cmd.op   = OP_SET_X_A;
					cmd.rsel = RS_A;
					state_d  = S_SETX;
				end else if (st.scan_end) begin
					cmd.op  = OP_SET_FULL;
					state_d = S_PUSH;
				end else begin
					cmd.op = OP_SCAN;
				end
			end
			S_SETX: begin
				if (st.cmd == CMD_INS_BEFORE) begin
					cmd.op = OP_SET_X_PREV;
				end
				state_d = S_RX;
			end
			S_RX: begin
				cmd.rsel = RS_X;
				state_d  = S_BASE;
			end
			S_BASE: begin
				cmd.op  = OP_BASE;
				state_d = S_WRD;
			end
			S_WRD: begin
				cmd.rsel = RS_XJ;
				state_d  = st.empty ? S_LK1 : S_WEV;
			end
			S_WEV: begin
				cmd.op   = OP_WALK;
				cmd.rsel = RS_XJ;
				state_d  = st.walk_stop ? S_DGO : S_WRD;
			end
			S_DGO: begin
				cmd.op  = OP_DIV_GO;
				state_d = S_DWT;
			end
			S_DWT: begin
				if (!st.div_busy) begin
					state_d = S_RLI;
				end
			end
			S_RLI: begin
				cmd.op  = OP_RL_INIT;
				state_d = S_RLW;
			end
			S_RLW: begin
				if (st.k_done) begin
					state_d = S_LK1;
				end else begin
					cmd.op   = OP_RL_WR;
					cmd.rsel = RS_XK;
					state_d  = S_RLN;
				end
			end
			S_RLN: begin
				cmd.op  = OP_RL_NX;
				state_d = S_RLW;
			end
			S_LK1: begin
				cmd.op  = OP_LINK1;
				state_d = S_LK2;
			end
			S_LK2: begin
				cmd.op  = OP_LINK2;
				state_d = S_PUSH;
			end
			S_C1: begin
				cmd.op   = OP_CAP0;
				cmd.rsel = RS_A;
				state_d  = S_C2;
			end
			S_C2: begin
				cmd.op   = OP_CAPA;
				cmd.rsel = RS_B;
				state_d  = S_C3;
			end
			S_C3: begin
				cmd.op  = OP_CMP;
				state_d = S_PUSH;
			end
			S_DEL: begin
				cmd.op  = OP_DEL;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (st.out_free) begin
					cmd.op  = OP_PUSH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end
endmodule

// File: rtl/order_maintenance_tag_list_unit.sv
// ----------------------------------------------------------------------------
// order_maintenance_tag_list_unit: ordered list with integer tags
// Keeps one circular ordered list of nodes in a fixed pool; slot 0 is the base.
// ----------------------------------------------------------------------------
// The req channel takes one command word (insert after, insert before,
// compare, delete) with its node slots; the rsp channel returns one result
// word per command with status, the new slot and the compare outcome.
// One command is worked on at a time. A command is taken only while the
// block is idle, which it may be while the previous result still waits.
// Compare captures the base and node a tags before it compares, and delete
// relinks the neighbours of node a. An insert scans the occupancy bits
// eight slots per cycle, then walks successors through the link memory.
// Every insert into a nonempty list then runs a bit-serial divider, and
// each respaced node is rewritten in turn.
// After reset the block writes the base node and then accepts commands.
// A stalled receiver holds the finished result in the output register;
// the next command may be taken but its result waits.
// ----------------------------------------------------------------------------
module order_maintenance_tag_list_unit #(
	parameter int POOL_NODES = omtl_pkg::POOL_NODES_DEF,
	parameter int TAG_BITS   = omtl_pkg::TAG_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	omtl_req_if.sink  req,
	omtl_rsp_if.source rsp
);
	import omtl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	omtl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	omtl_dp #(
		.POOL_NODES (POOL_NODES),
		.TAG_BITS   (TAG_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.req_command      (req.command),
		.req_node_a       (req.node_a),
		.req_node_b       (req.node_b),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_status       (rsp.status),
		.rsp_new_node     (rsp.new_node),
		.rsp_order_result (rsp.order_result)
	);
endmodule

// File: dv/omtl_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// omtl_checker: result predictor and scoreboard for the tag list unit
// Watches both channels, keeps its own copy of the node pool, predicts one
// result word per accepted command word and compares results in order.
// ----------------------------------------------------------------------------
module omtl_checker (
	input logic  clk,
	input logic  arst_n,
	omtl_req_if  req,
	omtl_rsp_if  rsp,
	output int   fails,
	output int   pending
);
	import omtl_pkg::*;

	localparam int NODES = POOL_NODES_DEF;
	localparam longint unsigned GAP_FULL = 64'd1 << TAG_BITS_DEF;

	typedef struct packed {
		stat_t                   status;
		logic [NODE_W-1:0]       new_node;
		logic signed [ORD_W-1:0] order_result;
	} list_result_t;

	logic [TAG_BITS_DEF-1:0] tag[NODES];
	logic [NODE_W-1:0]       succ[NODES];
	logic [NODE_W-1:0]       pred[NODES];
	bit                      busy_slot[NODES];
	list_result_t            expected_results[$];

	function automatic longint unsigned gap(input int n, input logic [TAG_BITS_DEF-1:0] base);
		logic [TAG_BITS_DEF-1:0] d;
		d = tag[n] - base;
		return longint'(d);
	endfunction

	function automatic void link_after(input int x, input int h);
		int nx, xj, xk;
		longint unsigned j, k, wj;
		logic [TAG_BITS_DEF-1:0] base, d;
		nx = int'(succ[x]);
		if (nx == x) begin
			tag[h] = {1'b0, {(TAG_BITS_DEF-1){1'b1}}};
		end else begin
			base = tag[x];
			j = 1;
			xj = nx;
			wj = gap(xj, base);
			if (wj == 0)
				wj = GAP_FULL;
			while (wj <= j * j && wj != GAP_FULL) begin
				j++;
				xj = int'(succ[xj]);
				wj = gap(xj, base);
				if (xj == x || wj == 0 || j > NODES) begin
					wj = GAP_FULL;
					break;
				end
			end
			xk = nx;
			for (k = 1; k < j; k++) begin
				tag[xk] = TAG_BITS_DEF'((wj * k) / j + base);
				xk = int'(succ[xk]);
			end
			d = tag[nx] - base;
			tag[h] = base + (d >> 1);
		end
		pred[h] = NODE_W'(x);
		succ[h] = NODE_W'(nx);
		pred[nx] = NODE_W'(h);
		succ[x] = NODE_W'(h);
		busy_slot[h] = 1'b1;
	endfunction

	function automatic list_result_t apply_command(input cmd_t cmd, input int a, input int b);
		list_result_t r;
		int h, x;
		logic [TAG_BITS_DEF-1:0] ta, tb;
		r = '{STAT_OK, '0, ORD_SAME};
		case (cmd)
			CMD_INS_AFTER, CMD_INS_BEFORE: begin
				if (!busy_slot[a]) begin
					r.status = STAT_INVALID;
				end else begin
					h = 0;
					for (int s = NODES - 1; s >= 1; s--)
						if (!busy_slot[s])
							h = s;
					x = (cmd == CMD_INS_BEFORE) ? int'(pred[a]) : a;
					if (h == 0) begin
						r.status = STAT_FULL;
					end else begin
						link_after(x, h);
						r.new_node = NODE_W'(h);
					end
				end
			end
			CMD_COMPARE: begin
				if (!busy_slot[a] || !busy_slot[b]) begin
					r.status = STAT_INVALID;
				end else begin
					ta = tag[a] - tag[0];
					tb = tag[b] - tag[0];
					if (ta > tb)
						r.order_result = ORD_B_FIRST;
					else if (ta < tb)
						r.order_result = ORD_A_FIRST;
				end
			end
			default: begin
				if (a == 0 || !busy_slot[a]) begin
					r.status = STAT_INVALID;
				end else begin
					succ[pred[a]] = succ[a];
					pred[succ[a]] = pred[a];
					busy_slot[a] = 1'b0;
					tag[a] = '0;
					succ[a] = '0;
					pred[a] = '0;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			for (int s = 0; s < NODES; s++) begin
				tag[s] = '0;
				succ[s] = '0;
				pred[s] = '0;
				busy_slot[s] = 1'b0;
			end
			busy_slot[0] = 1'b1;
			expected_results.delete();
			fails = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result word, status", rsp.status, -1);
				end else begin
					want = expected_results.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.new_node !== want.new_node)
						report_mismatch("new_node", rsp.new_node, want.new_node);
					if (rsp.order_result !== want.order_result)
						report_mismatch("order_result", rsp.order_result,
							want.order_result);
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(apply_command(cmd_t'(req.command),
					req.node_a, req.node_b));
		end
		pending = expected_results.size();
	end
endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the tag list unit
// Drives directed and random command words with random gaps and result
// stalls, fills the pool to overflow, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
	import omtl_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   idle_cycles;
	int   sent;
	bit   steady;

	omtl_req_if req ();
	omtl_rsp_if rsp ();

	order_maintenance_tag_list_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	omtl_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.fails(fails),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic int pick_node(input int hi);
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 255);
		return $urandom_range(0, hi);
	endfunction

	task automatic send_word(input cmd_t cmd, input int a, input int b);
		int n;
		n = draw_wait();
		repeat (n) @(negedge clk);
		req.command = cmd;
		req.node_a = NODE_W'(a);
		req.node_b = NODE_W'(b);
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		req.valid = 1'b0;
		sent++;
		steady = ((sent / 70) % 4) == 3;
	endtask

	task automatic send_mix(input int count, input int hi);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				send_word(CMD_INS_AFTER, pick_node(hi), $urandom_range(0, 255));
			else if (r < 55)
				send_word(CMD_INS_BEFORE, pick_node(hi), $urandom_range(0, 255));
			else if (r < 75)
				send_word(CMD_COMPARE, pick_node(hi), pick_node(hi));
			else if (r < 95)
				send_word(CMD_DELETE, pick_node(hi), $urandom_range(0, 255));
			else
				send_word(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 255),
					$urandom_range(0, 255));
		end
	endtask

	initial begin
		int n;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			n = draw_wait();
			rsp.ready = 1'b0;
			repeat (n) @(negedge clk);
			rsp.ready = 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_INS_AFTER;
		req.node_a = '0;
		req.node_b = '0;
		sent = 0;
		steady = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		send_word(CMD_INS_AFTER, 0, 0);
		send_word(CMD_COMPARE, 1, 0);
		send_word(CMD_COMPARE, 0, 1);
		send_word(CMD_COMPARE, 1, 1);
		send_word(CMD_INS_BEFORE, 1, 255);
		send_word(CMD_INS_BEFORE, 0, 0);
		send_word(CMD_INS_AFTER, 1, 0);
		send_word(CMD_INS_AFTER, 1, 0);
		send_word(CMD_INS_AFTER, 1, 0);
		send_word(CMD_DELETE, 0, 0);
		send_word(CMD_DELETE, 255, 0);
		send_word(CMD_INS_AFTER, 200, 0);
		send_word(CMD_INS_BEFORE, 255, 0);
		send_word(CMD_COMPARE, 255, 0);
		send_word(CMD_COMPARE, 2, 255);
		send_word(CMD_DELETE, 2, 0);
		send_word(CMD_COMPARE, 2, 1);
		send_word(CMD_COMPARE, 3, 4);
		send_word(CMD_DELETE, 1, 0);
		send_word(CMD_INS_AFTER, 3, 0);

		send_mix(300, 40);

		for (int i = 0; i < 280; i++) begin
			if (i % 3 == 0)
				send_word(CMD_INS_AFTER, 3, 0);
			else
				send_word(($urandom_range(0, 1) != 0) ? CMD_INS_AFTER : CMD_INS_BEFORE,
					$urandom_range(0, 255), $urandom_range(0, 255));
		end
		wait (pending == 0);
		send_word(CMD_COMPARE, 255, 0);

		for (int i = 0; i < 150; i++)
			send_word(CMD_DELETE, $urandom_range(1, 255), 0);
		send_mix(150, 255);

		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
